@@ hw/rtl/status_blink_classifier_macros.svh @@
// assertion macros for the status blink classifier
`ifndef STATUS_BLINK_CLASSIFIER_MACROS_SVH
`define STATUS_BLINK_CLASSIFIER_MACROS_SVH

// same-cycle implication, held off during reset
`define SBC_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sbc assertion failed");

// next-cycle implication, held off during reset
`define SBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sbc assertion failed");

`endif

@@ hw/rtl/sbc_pkg.sv @@
// shared types, constants and helpers of the status blink classifier
package sbc_pkg;

  localparam int TIME_BITS  = 16;
  localparam int REG_W      = 16;
  localparam int CMP_W      = (TIME_BITS > REG_W) ? TIME_BITS : REG_W;
  localparam int CFG_IDX_W  = 8;

  localparam logic [CFG_IDX_W-1:0] REG_BATTERY_QUIET   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CHARGING_PERIOD = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_PERIOD    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_CHARGER_QUIET   = CFG_IDX_W'(3);

  localparam logic [REG_W-1:0] BATTERY_QUIET_RST   = REG_W'(3000);
  localparam logic [REG_W-1:0] CHARGING_PERIOD_RST = REG_W'(2000);
  localparam logic [REG_W-1:0] ERROR_PERIOD_RST    = REG_W'(400);
  localparam logic [REG_W-1:0] CHARGER_QUIET_RST   = REG_W'(500);

  typedef logic [TIME_BITS-1:0] sbc_time_t;

  typedef struct packed {
    logic [REG_W-1:0] battery_quiet_timeout;
    logic [REG_W-1:0] charging_blink_period;
    logic [REG_W-1:0] error_blink_period;
    logic [REG_W-1:0] charger_quiet_timeout;
  } sbc_cfg_t;

  typedef struct packed {
    logic      bat_level;
    logic      chg_level;
    sbc_time_t bat_since;
    sbc_time_t bat_interval;
    sbc_time_t chg_since;
  } sbc_state_t;

  typedef struct packed {
    logic battery_charged;
    logic battery_charging;
    logic battery_fault;
    logic supply_connected;
    logic charger_fault;
  } sbc_flags_t;

  // saturating increment of a time count
  function automatic sbc_time_t sat_inc(input sbc_time_t v);
    return (v == '1) ? v : v + sbc_time_t'(1);
  endfunction

  // |a - b| for two values already extended to CMP_W bits
  function automatic logic [CMP_W-1:0] abs_diff(input logic [CMP_W-1:0] a,
                                                input logic [CMP_W-1:0] b);
    logic [CMP_W:0] d;
    logic [CMP_W:0] m;
    d = {1'b0, a} - {1'b0, b};
    m = d[CMP_W] ? (~d + (CMP_W+1)'(1)) : d;
    return m[CMP_W-1:0];
  endfunction

endpackage

@@ hw/rtl/sbc_ifaces.sv @@
// handshake channel interfaces of the status blink classifier

interface sbc_status_if;
  logic valid;
  logic ready;
  logic battery_level;
  logic charger_level;
  modport source (output valid, battery_level, charger_level, input ready);
  modport sink (input valid, battery_level, charger_level, output ready);
endinterface

interface sbc_flags_if;
  logic valid;
  logic ready;
  logic battery_charged;
  logic battery_charging;
  logic battery_fault;
  logic supply_connected;
  logic charger_fault;
  modport source (output valid, battery_charged, battery_charging, battery_fault,
                  supply_connected, charger_fault, input ready);
  modport sink (input valid, battery_charged, battery_charging, battery_fault,
                supply_connected, charger_fault, output ready);
endinterface

interface sbc_cfg_if import sbc_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [REG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/sbc_cfg_regs.sv @@
// configuration register file: timeouts and nominal blink periods
module sbc_cfg_regs import sbc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [REG_W-1:0]     wr_data,
  output sbc_cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.battery_quiet_timeout <= BATTERY_QUIET_RST;
      cfg.charging_blink_period <= CHARGING_PERIOD_RST;
      cfg.error_blink_period    <= ERROR_PERIOD_RST;
      cfg.charger_quiet_timeout <= CHARGER_QUIET_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_BATTERY_QUIET:   cfg.battery_quiet_timeout <= wr_data;
        REG_CHARGING_PERIOD: cfg.charging_blink_period <= wr_data;
        REG_ERROR_PERIOD:    cfg.error_blink_period    <= wr_data;
        REG_CHARGER_QUIET:   cfg.charger_quiet_timeout <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/sbc_tracker.sv @@
// edge detection and saturating since-edge / interval counters
module sbc_tracker import sbc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  logic       battery_level,
  input  logic       charger_level,
  output sbc_state_t state
);

  logic       bat_edge;
  logic       chg_edge;
  sbc_time_t  bat_since_inc;
  sbc_state_t state_next;

  assign bat_edge      = battery_level & ~state.bat_level;
  assign chg_edge      = charger_level & ~state.chg_level;
  assign bat_since_inc = sat_inc(state.bat_since);

  always_comb begin
    state_next.bat_level    = battery_level;
    state_next.chg_level    = charger_level;
    state_next.bat_since    = bat_edge ? '0 : bat_since_inc;
    state_next.bat_interval = bat_edge ? bat_since_inc : state.bat_interval;
    state_next.chg_since    = chg_edge ? '0 : sat_inc(state.chg_since);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.bat_level    <= 1'b1;
      state.chg_level    <= 1'b1;
      state.bat_since    <= '0;
      state.bat_interval <= '0;
      state.chg_since    <= '0;
    end else if (load) begin
      state <= state_next;
    end
  end

endmodule

@@ hw/rtl/sbc_classify.sv @@
// flag decode from updated counts, levels and configuration
module sbc_classify import sbc_pkg::*; (
  input  sbc_state_t state,
  input  sbc_cfg_t   cfg,
  output sbc_flags_t flags
);

  logic             bat_quiet;
  logic             chg_quiet;
  logic [CMP_W-1:0] interval_x;
  logic [CMP_W-1:0] dist_chg;
  logic [CMP_W-1:0] dist_err;

  assign bat_quiet  = CMP_W'(state.bat_since) >= CMP_W'(cfg.battery_quiet_timeout);
  assign chg_quiet  = CMP_W'(state.chg_since) >= CMP_W'(cfg.charger_quiet_timeout);
  assign interval_x = CMP_W'(state.bat_interval);
  assign dist_chg   = abs_diff(CMP_W'(cfg.charging_blink_period), interval_x);
  assign dist_err   = abs_diff(CMP_W'(cfg.error_blink_period), interval_x);

  // a tie between the two periods sets neither blink flag
  assign flags.battery_charged  = bat_quiet & state.bat_level;
  assign flags.battery_charging = ~bat_quiet & (dist_chg < dist_err);
  assign flags.battery_fault    = ~bat_quiet & (dist_err < dist_chg);
  assign flags.supply_connected = chg_quiet & state.chg_level;
  assign flags.charger_fault    = ~chg_quiet;

endmodule

@@ hw/rtl/status_blink_classifier.sv @@
// top level of the status blink classifier
//
//  channel  dir  handshake      payload
//  status   in   valid / ready  battery_level, charger_level (one per ms tick)
//  flags    out  valid / ready  battery_charged, battery_charging, battery_fault,
//                               supply_connected, charger_fault
//  cfg      in   valid / ready  index, data (register write, always ready)
//
// one request per cycle sustained while flags.ready holds
// the tracker counters double as the first stage register, the flag register the second
// rst (synchronous) clears both valid bits, counters to zero, previous levels to one
// and loads the register defaults
// a stalled result holds one more request in the counters; then status.ready drops
`include "status_blink_classifier_macros.svh"

module status_blink_classifier import sbc_pkg::*; (
  input logic        clk,
  input logic        rst,
  sbc_status_if.sink status,
  sbc_flags_if.source flags,
  sbc_cfg_if.sink    cfg
);

  // stage 1 valid: tracker state holds an updated snapshot not yet decoded
  logic       s1_valid;
  // result register
  logic       out_valid;
  sbc_flags_t out_flags;

  logic       out_free;
  logic       s1_move;
  logic       in_take;

  sbc_cfg_t   cfg_regs;
  sbc_state_t trk_state;
  sbc_flags_t flags_comb;

  // result slot frees when empty or being taken this cycle
  assign out_free     = ~out_valid | flags.ready;
  assign s1_move      = s1_valid & out_free;
  // counters may be overwritten only once their snapshot has moved on
  assign in_take      = status.valid & status.ready;
  assign status.ready = ~s1_valid | out_free;

  // configuration writes never stall
  assign cfg.ready = 1'b1;

  sbc_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_regs)
  );

  sbc_tracker u_tracker (
    .clk           (clk),
    .rst           (rst),
    .load          (in_take),
    .battery_level (status.battery_level),
    .charger_level (status.charger_level),
    .state         (trk_state)
  );

  sbc_classify u_classify (
    .state (trk_state),
    .cfg   (cfg_regs),
    .flags (flags_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (flags.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_flags <= flags_comb;
    end
  end

  assign flags.valid            = out_valid;
  assign flags.battery_charged  = out_flags.battery_charged;
  assign flags.battery_charging = out_flags.battery_charging;
  assign flags.battery_fault    = out_flags.battery_fault;
  assign flags.supply_connected = out_flags.supply_connected;
  assign flags.charger_fault    = out_flags.charger_fault;

  // charging and fault exclude each other, a tie sets neither
  `SBC_ASSERT_SAME(a_blink_exclusive, clk, rst, out_valid,
                   !(out_flags.battery_charging && out_flags.battery_fault))
  // steady supply and charger fault cannot both hold
  `SBC_ASSERT_SAME(a_charger_exclusive, clk, rst, out_valid,
                   !(out_flags.supply_connected && out_flags.charger_fault))
  // a battery rising edge restarts its count
  `SBC_ASSERT_NEXT(a_bat_edge_restart, clk, rst,
                   in_take && status.battery_level && !trk_state.bat_level,
                   trk_state.bat_since == '0)
  // a full stage 1 behind a stalled result blocks new requests
  `SBC_ASSERT_SAME(a_stall_blocks, clk, rst,
                   s1_valid && out_valid && !flags.ready, !status.ready)

endmodule
